[rtl/umwps_pkg.sv]
// shared types and constants for the masked word pattern scan
// used by the channel interfaces, the window cells, the tally stage and the top level

package umwps_pkg;

  localparam int WORD_BITS     = 32;
  localparam int WINDOW_WORDS  = 32;
  localparam int IDX_BITS      = 5;
  localparam int LEN_BITS      = 6;
  localparam int ANCHOR_WORDS  = 4;
  localparam int POSITION_BITS = 20;
  localparam int COUNT_BITS    = POSITION_BITS + 1;
  localparam int STATUS_BITS   = 2;
  localparam int CFG_IDX_BITS  = 1;

  localparam logic [LEN_BITS-1:0] LEN_MIN = LEN_BITS'(ANCHOR_WORDS);
  localparam logic [LEN_BITS-1:0] LEN_MAX = LEN_BITS'(WINDOW_WORDS);
  localparam logic [LEN_BITS-1:0] LEN_RESET = LEN_BITS'(4);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_DATA = 1'b1;

  localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_LENGTH = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_WILDCARD_MASK  = 1'b1;

  localparam logic [STATUS_BITS-1:0] STATUS_NONE      = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_UNIQUE    = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_AMBIGUOUS = 2'd2;

  typedef struct packed {
    logic [WORD_BITS-1:0] word;
    logic                 care;
  } lane_t;

  typedef struct packed {
    logic                  valid;
    logic                  last;
    logic                  window_ok;
    logic [COUNT_BITS-1:0] count;
  } judge_t;

endpackage

[rtl/umwps_in_if.sv]
// input channel of the scan: valid/ready handshake with one item per transfer
// depends on umwps_pkg for field widths

interface umwps_in_if;
  logic                               valid;
  logic                               ready;
  logic                               opcode;
  logic [umwps_pkg::IDX_BITS-1:0]     pattern_index;
  logic [umwps_pkg::WORD_BITS-1:0]    word;
  logic                               last_word;

  modport source (output valid, opcode, pattern_index, word, last_word, input ready);
  modport sink (input valid, opcode, pattern_index, word, last_word, output ready);
endinterface

[rtl/umwps_out_if.sv]
// result channel of the scan: valid/ready handshake with one item per transfer
// depends on umwps_pkg for field widths

interface umwps_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [umwps_pkg::STATUS_BITS-1:0]    status;
  logic [umwps_pkg::POSITION_BITS-1:0]  match_position;

  modport source (output valid, status, match_position, input ready);
  modport sink (input valid, status, match_position, output ready);
endinterface

[rtl/umwps_cell.sv]
// one window cell: holds one recent data word, hands it to the next cell on a shift
// and compares it against the pattern word aligned to it; depends on umwps_pkg

module umwps_cell (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            shift_i,
  input  logic                            clear_i,
  input  logic [umwps_pkg::WORD_BITS-1:0] word_i,
  input  umwps_pkg::lane_t                lane_i,
  output logic [umwps_pkg::WORD_BITS-1:0] word_o,
  output logic                            ok_o
);

  logic [umwps_pkg::WORD_BITS-1:0] data_q, data_d;

  assign data_d = clear_i ? '0 : word_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else if (shift_i) begin
      data_q <= data_d;
    end
  end

  assign word_o = data_q;
  assign ok_o   = !lane_i.care || (data_q == lane_i.word);

endmodule

[rtl/umwps_tally.sv]
// match tally: counts window hits per region, keeps the first offset and holds
// the result register of the output channel; depends on umwps_pkg

module umwps_tally (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                adv_i,
  input  umwps_pkg::judge_t                   judge_i,
  input  logic [umwps_pkg::LEN_BITS-1:0]      len_i,
  output logic                                valid_o,
  output logic [umwps_pkg::STATUS_BITS-1:0]   status_o,
  output logic [umwps_pkg::POSITION_BITS-1:0] position_o
);

  logic [1:0]                          found_q, found_d, found_n;
  logic [umwps_pkg::POSITION_BITS-1:0] first_q, first_d, first_n;
  logic                                valid_q, valid_d;
  logic [umwps_pkg::STATUS_BITS-1:0]   status_q, status_d;
  logic [umwps_pkg::POSITION_BITS-1:0] pos_q, pos_d;
  logic [umwps_pkg::COUNT_BITS-1:0]    offset;
  logic                                hit;

  assign offset = judge_i.count - umwps_pkg::COUNT_BITS'(len_i);
  assign hit = judge_i.valid && judge_i.window_ok
               && (judge_i.count >= umwps_pkg::COUNT_BITS'(len_i))
               && !offset[umwps_pkg::COUNT_BITS-1];

  always_comb begin
    found_n = found_q;
    first_n = first_q;
    if (hit) begin
      if (found_q == 2'd0) begin
        first_n = offset[umwps_pkg::POSITION_BITS-1:0];
      end
      if (found_q != 2'd2) begin
        found_n = found_q + 2'd1;
      end
    end
  end

  always_comb begin
    found_d  = found_q;
    first_d  = first_q;
    valid_d  = valid_q;
    status_d = status_q;
    pos_d    = pos_q;
    if (adv_i) begin
      valid_d = judge_i.valid && judge_i.last;
      if (judge_i.valid) begin
        if (judge_i.last) begin
          found_d = 2'd0;
          first_d = '0;
          case (found_n)
            2'd0:    status_d = umwps_pkg::STATUS_NONE;
            2'd1:    status_d = umwps_pkg::STATUS_UNIQUE;
            default: status_d = umwps_pkg::STATUS_AMBIGUOUS;
          endcase
          pos_d = (found_n == 2'd1) ? first_n : '0;
        end else begin
          found_d = found_n;
          first_d = first_n;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 2'd0;
      first_q <= '0;
      valid_q <= 1'b0;
    end else begin
      found_q <= found_d;
      first_q <= first_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    pos_q    <= pos_d;
  end

  assign valid_o    = valid_q;
  assign status_o   = status_q;
  assign position_o = pos_q;

endmodule

[rtl/unique_masked_word_pattern_scan.sv]
// top level of the masked word pattern scan: pattern store, configuration,
// row of window cells and tally; depends on umwps_pkg, the channel interfaces,
// umwps_cell and umwps_tally
//
// usage:
//   in_ch carries items: opcode 0 writes word into pattern slot pattern_index,
//   opcode 1 shifts word into the 32-word window of the current region.
//   an opcode 1 item with last_word set closes the region; one item then
//   leaves on out_ch with status (none, unique, ambiguous) and the offset of
//   the unique match.
//   the cfg port writes pattern_length (index 0) and wildcard_mask (index 1)
//   on any edge with cfg_we_i high.
// throughput and pipeline:
//   one item per cycle on in_ch while in_ch.ready is high. the window
//   shifts on the accepting edge; window compare and tally read the registered
//   window, and the result register loads when the pipeline advances.
// reset:
//   window, word count and tally clear; pattern_length 4, wildcard_mask 0;
//   the pattern store holds no defined value until written.
// stall:
//   while a result waits and out_ch.ready is low, in_ch.ready is low and the
//   whole pipeline holds.

module unique_masked_word_pattern_scan (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  umwps_in_if.sink                             in_ch,
  umwps_out_if.source                          out_ch,
  input  logic                                 cfg_we_i,
  input  logic [umwps_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [umwps_pkg::WORD_BITS-1:0]      cfg_data_i
);

  localparam int W = umwps_pkg::WINDOW_WORDS;

  logic                                adv;
  logic                                take;
  logic                                take_data;
  logic [umwps_pkg::LEN_BITS-1:0]      plen_q;
  logic [umwps_pkg::WORD_BITS-1:0]     mask_q;
  logic [umwps_pkg::LEN_BITS-1:0]      len;
  logic [umwps_pkg::IDX_BITS-1:0]      amt;
  logic [umwps_pkg::WORD_BITS-1:0]     pattern_q [W];
  logic                                restart_q;
  logic [umwps_pkg::COUNT_BITS-1:0]    count_q, count_d;
  logic                                s2_valid_q, s2_last_q;
  logic [umwps_pkg::WORD_BITS-1:0]     chain [W];
  logic [W-1:0]                        ok;
  umwps_pkg::lane_t                    lanes [W];
  umwps_pkg::judge_t                   judge;

  assign adv       = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;
  assign take      = in_ch.valid && adv;
  assign take_data = take && (in_ch.opcode == umwps_pkg::OP_DATA);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q <= umwps_pkg::LEN_RESET;
      mask_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        umwps_pkg::REG_PATTERN_LENGTH: plen_q <= cfg_data_i[umwps_pkg::LEN_BITS-1:0];
        umwps_pkg::REG_WILDCARD_MASK:  mask_q <= cfg_data_i;
      endcase
    end
  end

  always_comb begin
    len = plen_q;
    if (plen_q < umwps_pkg::LEN_MIN) len = umwps_pkg::LEN_MIN;
    if (plen_q > umwps_pkg::LEN_MAX) len = umwps_pkg::LEN_MAX;
  end

  // pattern store
  always_ff @(posedge clk_i) begin
    if (take && (in_ch.opcode == umwps_pkg::OP_LOAD)) begin
      pattern_q[in_ch.pattern_index] <= in_ch.word;
    end
  end

  // align pattern word len-1-k to cell k: reverse, then rotate by 32-len
  assign amt = umwps_pkg::IDX_BITS'(umwps_pkg::LEN_MAX - len);

  always_comb begin
    umwps_pkg::lane_t v  [W];
    umwps_pkg::lane_t nx [W];
    for (int m = 0; m < W; m++) begin
      v[m].word = pattern_q[W-1-m];
      v[m].care = (umwps_pkg::LEN_BITS'(W-1-m) < len)
                  && !(((W-1-m) >= umwps_pkg::ANCHOR_WORDS) && mask_q[W-1-m]);
    end
    for (int s = 0; s < umwps_pkg::IDX_BITS; s++) begin
      for (int k = 0; k < W; k++) begin
        nx[k] = amt[s] ? v[(k + (1 << s)) % W] : v[k];
      end
      for (int k = 0; k < W; k++) begin
        v[k] = nx[k];
      end
    end
    for (int k = 0; k < W; k++) begin
      lanes[k] = v[k];
    end
  end

  // window cells
  for (genvar k = 0; k < W; k++) begin : g_cell
    if (k == 0) begin : g_head
      umwps_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (take_data),
        .clear_i (1'b0),
        .word_i  (in_ch.word),
        .lane_i  (lanes[k]),
        .word_o  (chain[k]),
        .ok_o    (ok[k])
      );
    end else begin : g_body
      umwps_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (take_data),
        .clear_i (restart_q),
        .word_i  (chain[k-1]),
        .lane_i  (lanes[k]),
        .word_o  (chain[k]),
        .ok_o    (ok[k])
      );
    end
  end

  // region word count and compare stage control
  always_comb begin
    count_d = count_q;
    if (take_data) begin
      if (restart_q) begin
        count_d = umwps_pkg::COUNT_BITS'(1);
      end else if (count_q != umwps_pkg::COUNT_MAX) begin
        count_d = count_q + umwps_pkg::COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      restart_q  <= 1'b0;
      s2_valid_q <= 1'b0;
      s2_last_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      if (take_data) begin
        restart_q <= in_ch.last_word;
      end
      if (adv) begin
        s2_valid_q <= take_data;
        s2_last_q  <= in_ch.last_word;
      end
    end
  end

  assign judge.valid     = s2_valid_q;
  assign judge.last      = s2_last_q;
  assign judge.window_ok = &ok;
  assign judge.count     = count_q;

  umwps_tally u_tally (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .judge_i    (judge),
    .len_i      (len),
    .valid_o    (out_ch.valid),
    .status_o   (out_ch.status),
    .position_o (out_ch.match_position)
  );

endmodule

[tb/sv/tb_unique_masked_word_pattern_scan.sv]
`timescale 1ns / 100ps
// testbench for unique_masked_word_pattern_scan: streams pattern loads and data regions with
// planted, damaged and overlapping copies of the pattern and checks every region verdict
// depends on umwps_pkg, umwps_in_if, umwps_out_if and the rtl top level

module tb_unique_masked_word_pattern_scan;
  import umwps_pkg::*;

  localparam int RUN_LIMIT     = 100000;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 140;

  typedef struct {
    logic                 opcode;
    logic [IDX_BITS-1:0]  slot;
    logic [WORD_BITS-1:0] word;
    logic                 last;
  } scan_item_t;

  typedef struct {
    logic [STATUS_BITS-1:0]   status;
    logic [POSITION_BITS-1:0] position;
  } verdict_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i;
  logic [CFG_IDX_BITS-1:0] cfg_index_i;
  logic [WORD_BITS-1:0]    cfg_data_i;

  umwps_in_if  in_ch ();
  umwps_out_if out_ch ();

  unique_masked_word_pattern_scan u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  scan_item_t  item_q[$];
  verdict_t    verdict_q[$];
  int unsigned send_gap = 0;
  int unsigned recv_stall = 0;
  bit          idle_on = 1'b1;
  bit          in_fire = 1'b0;
  bit          out_fire = 1'b0;
  int unsigned cycles = 0;
  int unsigned errors = 0;
  int unsigned items_pushed = 0;
  int unsigned items_taken = 0;
  int unsigned verdicts_checked = 0;
  int unsigned verdict_count[3] = '{0, 0, 0};

  // predictor state
  logic [WORD_BITS-1:0]     pred_pattern[WINDOW_WORDS];
  logic [WORD_BITS-1:0]     pred_recent[WINDOW_WORDS];
  logic [COUNT_BITS-1:0]    pred_seen;
  logic [1:0]               pred_hits;
  logic [POSITION_BITS-1:0] pred_first;
  logic [LEN_BITS-1:0]      pred_len_reg;
  logic [WORD_BITS-1:0]     pred_mask_reg;

  // stimulus side view of pattern and settings
  logic [WORD_BITS-1:0] gen_pattern[WINDOW_WORDS];
  int                   gen_len;
  logic [WORD_BITS-1:0] gen_mask;

  function automatic int effective_len(logic [LEN_BITS-1:0] raw);
    int n;
    n = int'(raw);
    if (n < ANCHOR_WORDS) n = ANCHOR_WORDS;
    if (n > WINDOW_WORDS) n = WINDOW_WORDS;
    return n;
  endfunction

  function automatic bit window_hit(int n);
    bit wild;
    for (int i = 0; i < n; i++) begin
      // anchor words always compare exactly
      wild = (i >= ANCHOR_WORDS) && pred_mask_reg[i];
      if (!wild && pred_recent[n-1-i] !== pred_pattern[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic clear_window();
    for (int k = 0; k < WINDOW_WORDS; k++) pred_recent[k] = '0;
    pred_seen = '0;
    pred_hits = '0;
    pred_first = '0;
  endtask

  task automatic scan_predict(scan_item_t it);
    int       n;
    int       off;
    verdict_t v;
    if (it.opcode == OP_LOAD) begin
      pred_pattern[it.slot] = it.word;
    end else begin
      for (int k = WINDOW_WORDS - 1; k > 0; k--) pred_recent[k] = pred_recent[k-1];
      pred_recent[0] = it.word;
      if (pred_seen != COUNT_MAX) pred_seen = pred_seen + 1'b1;
      n = effective_len(pred_len_reg);
      if (pred_seen >= n) begin
        off = pred_seen - n;
        if (off < (1 << POSITION_BITS) && window_hit(n)) begin
          if (pred_hits == 0) pred_first = POSITION_BITS'(off);
          if (pred_hits < 2) pred_hits = pred_hits + 1'b1;
        end
      end
      if (it.last) begin
        case (pred_hits)
          2'd0:    v.status = STATUS_NONE;
          2'd1:    v.status = STATUS_UNIQUE;
          default: v.status = STATUS_AMBIGUOUS;
        endcase
        v.position = (pred_hits == 1) ? pred_first : '0;
        verdict_q.push_back(v);
        clear_window();
      end
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    errors++;
    $display("mismatch in %s at cycle %0d: expected %0h, got %0h", what, cycles, want, got);
  endtask

  // input driver
  always @(negedge clk_i) begin
    scan_item_t nxt;
    if (rst_ni && (!in_ch.valid || in_fire)) begin
      if (send_gap > 0) begin
        in_ch.valid <= 1'b0;
        send_gap--;
      end else if (item_q.size() > 0) begin
        nxt = item_q.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.opcode <= nxt.opcode;
        in_ch.pattern_index <= nxt.slot;
        in_ch.word <= nxt.word;
        in_ch.last_word <= nxt.last;
        send_gap = idle_on ? $urandom_range(0, 8) : 0;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result ready, one stall drawn per result
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_fire) recv_stall = idle_on ? $urandom_range(0, 8) : 0;
      if (recv_stall > 0) begin
        out_ch.ready <= 1'b0;
        recv_stall--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // monitor: predicts on accepted items, checks accepted results
  always @(posedge clk_i) begin
    scan_item_t taken_item;
    verdict_t   want;
    cycles++;
    in_fire = rst_ni && in_ch.valid && in_ch.ready;
    out_fire = rst_ni && out_ch.valid && out_ch.ready;
    if (in_fire) begin
      taken_item.opcode = in_ch.opcode;
      taken_item.slot = in_ch.pattern_index;
      taken_item.word = in_ch.word;
      taken_item.last = in_ch.last_word;
      items_taken++;
      scan_predict(taken_item);
    end
    if (out_fire) begin
      if (verdict_q.size() == 0) begin
        report_mismatch("unexpected result", '0,
                        32'({out_ch.status, out_ch.match_position}));
      end else begin
        want = verdict_q.pop_front();
        verdicts_checked++;
        verdict_count[want.status]++;
        if (out_ch.status !== want.status)
          report_mismatch("status", 32'(want.status), 32'(out_ch.status));
        if (out_ch.match_position !== want.position)
          report_mismatch("match_position", 32'(want.position),
                          32'(out_ch.match_position));
      end
    end
  end

  task automatic push_item(logic op, logic [IDX_BITS-1:0] slot, logic [WORD_BITS-1:0] word,
                           logic last);
    scan_item_t it;
    it.opcode = op;
    it.slot = slot;
    it.word = word;
    it.last = last;
    item_q.push_back(it);
    items_pushed++;
    if (op == OP_LOAD) gen_pattern[slot] = word;
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [WORD_BITS-1:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_PATTERN_LENGTH) begin
      pred_len_reg = value[LEN_BITS-1:0];
      gen_len = effective_len(value[LEN_BITS-1:0]);
    end else begin
      pred_mask_reg = value;
      gen_mask = value;
    end
  endtask

  // wait until every item is taken and every result checked, then let the pipe settle
  task automatic drain();
    while (items_taken != items_pushed || verdict_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic load_pattern(int unsigned style);
    logic [WORD_BITS-1:0] base0;
    logic [WORD_BITS-1:0] base1;
    logic [WORD_BITS-1:0] w;
    base0 = $urandom;
    base1 = $urandom;
    for (int s = 0; s < WINDOW_WORDS; s++) begin
      case (style)
        0:       w = $urandom;
        1:       w = (s % 2 == 0) ? base0 : base1;
        2:       w = '0;
        default: w = '1;
      endcase
      push_item(OP_LOAD, IDX_BITS'(s), w, 1'($urandom_range(0, 1)));
    end
  endtask

  // one region of data words with planted copies of the current pattern
  task automatic push_region(int words, int plants, bit damage, bit close_it);
    logic [WORD_BITS-1:0] region_words[];
    int                   n;
    int                   at;
    int                   spot;
    int                   s;
    n = gen_len;
    region_words = new[words];
    for (int i = 0; i < words; i++)
      region_words[i] = $urandom_range(0, 1) ? $urandom : gen_pattern[$urandom_range(0, n - 1)];
    if (words >= n) begin
      for (int p = 0; p < plants; p++) begin
        case ($urandom_range(0, 3))
          0:       at = 0;
          1:       at = words - n;
          default: at = $urandom_range(0, words - n);
        endcase
        for (int i = 0; i < n; i++)
          region_words[at+i] = (i >= ANCHOR_WORDS && gen_mask[i] && $urandom_range(0, 1)) ?
                               $urandom : gen_pattern[i];
        if (damage) begin
          spot = $urandom_range(0, n - 1);
          region_words[at+spot] ^= (32'd1 << $urandom_range(0, 31));
        end
      end
    end
    for (int i = 0; i < words; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        s = $urandom_range(0, WINDOW_WORDS - 1);
        push_item(OP_LOAD, IDX_BITS'(s),
                  (s < n && $urandom_range(0, 1)) ? gen_pattern[s] : $urandom,
                  1'($urandom_range(0, 1)));
      end
      push_item(OP_DATA, IDX_BITS'($urandom), region_words[i], close_it && i == words - 1);
    end
  endtask

  initial begin
    logic [WORD_BITS-1:0] dir_words[22];
    bit                   dir_ends[22];
    logic [WORD_BITS-1:0] len_sets[PHASES];
    logic [WORD_BITS-1:0] mask_sets[PHASES];
    int unsigned          start;
    int                   words;
    int                   plants;
    int unsigned          pick;

    in_ch.valid = 1'b0;
    in_ch.opcode = OP_LOAD;
    in_ch.pattern_index = '0;
    in_ch.word = '0;
    in_ch.last_word = 1'b0;
    out_ch.ready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = REG_PATTERN_LENGTH;
    cfg_data_i = '0;

    for (int k = 0; k < WINDOW_WORDS; k++) begin
      pred_pattern[k] = '0;
      gen_pattern[k] = '0;
    end
    clear_window();
    pred_len_reg = LEN_RESET;
    pred_mask_reg = '0;
    gen_len = effective_len(LEN_RESET);
    gen_mask = '0;

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: four anchor words, no wildcards
    push_item(OP_LOAD, IDX_BITS'(0), 32'h0000_0000, 1'b0);
    push_item(OP_LOAD, IDX_BITS'(1), 32'hFFFF_FFFF, 1'b1);
    push_item(OP_LOAD, IDX_BITS'(2), 32'hA5A5_A5A5, 1'b0);
    push_item(OP_LOAD, IDX_BITS'(3), 32'h5A5A_5A5A, 1'b0);
    // region too short, exact fit, two matches, offset one, damaged anchor
    dir_words = '{32'h0000_0000,
                  32'h0000_0000, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 32'h5A5A_5A5A,
                  32'h0000_0000, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 32'h5A5A_5A5A,
                  32'h0000_0000, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 32'h5A5A_5A5A,
                  32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 32'h5A5A_5A5A,
                  32'h0000_0000, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 32'h5A5A_5A5B};
    dir_ends = '{1, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 1, 0, 0, 0, 1};
    for (int i = 0; i < 22; i++)
      push_item(OP_DATA, IDX_BITS'($urandom), dir_words[i], dir_ends[i]);

    len_sets = '{32'd32, 32'd0, 32'd63, 32'hABCD_EF21, 32'd8,
                 32'd4, 32'd5, $urandom, $urandom, 32'hFFFF_FFE0};
    mask_sets = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, $urandom, 32'hAAAA_AAAA,
                  32'h0000_000F, 32'h0000_0010, $urandom, $urandom, 32'h7FFF_FFF0};

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      idle_on = (ph % 4 != 3);
      write_reg(REG_PATTERN_LENGTH, len_sets[ph]);
      write_reg(REG_WILDCARD_MASK, mask_sets[ph]);
      if (ph == 0) load_pattern(0);
      else if ($urandom_range(0, 2) == 0) load_pattern($urandom_range(0, 3));
      start = items_pushed;
      while (items_pushed - start < PHASE_ITEMS) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) words = $urandom_range(1, gen_len - 1);
        else if (pick == 1) words = gen_len;
        else words = gen_len + $urandom_range(0, 20);
        pick = $urandom_range(0, 9);
        plants = (pick < 2) ? 0 : (pick < 8) ? 1 : 2;
        push_region(words, plants, $urandom_range(0, 4) == 0, 1'b1);
      end
      // sometimes a region stays open across the next register change
      if ($urandom_range(0, 2) == 0) push_region($urandom_range(1, gen_len), 1, 1'b0, 1'b0);
    end
    drain();

    $display("covered %0d items over %0d register settings, %0d region results checked",
             items_taken, PHASES + 1, verdicts_checked);
    $display("results seen: %0d without match, %0d unique, %0d ambiguous",
             verdict_count[STATUS_NONE], verdict_count[STATUS_UNIQUE],
             verdict_count[STATUS_AMBIGUOUS]);
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    while (cycles < RUN_LIMIT) @(posedge clk_i);
    $display("run stopped after %0d cycles", RUN_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
